/* design/efp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package efp_pkg;

  // Fixed field widths and frame constants.
  localparam int MAC_W           = 48;
  localparam int TYPE_W          = 16;
  localparam int PAYLOAD_W       = 11;
  localparam int FCS_W           = 32;
  localparam int MIN_FRAME_BYTES = 18;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Frame status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_LONG     = 2'd3
  } status_t;

  // Frame contents as seen with the current byte included.
  typedef struct packed {
    logic [MAC_W-1:0]     dest;
    logic [MAC_W-1:0]     source;
    logic [TYPE_W-1:0]    ether_type;
    logic [PAYLOAD_W-1:0] plen;
    logic [FCS_W-1:0]     fcs;
    logic [31:0]          crc;
    logic                 too_short;
    logic                 too_long;
  } frame_view_t;

  // One result item.
  typedef struct packed {
    logic [MAC_W-1:0]     dest;
    logic [MAC_W-1:0]     source;
    logic [TYPE_W-1:0]    ether_type;
    logic [PAYLOAD_W-1:0] plen;
    logic [FCS_W-1:0]     fcs;
    status_t              status;
  } result_t;

  // Reflected CRC-32 update over one byte, least significant bit first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/ethernet_frame_parser_fcs_check.sv */
// Each result is registered, into the skid stage if the output register is held.
// Throughput: one byte per cycle while in_stall is low; the byte-wide CRC update and header capture keep up.
// The output register and a one-entry skid stage absorb two results; in_stall rises
// only when both are held by out_stall.
// Reset (rst, synchronous): clears frame state, sets the FCS check on, empties output.
`timescale 1ns / 1ps
`default_nettype none

module ethernet_frame_parser_fcs_check
  import efp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 frame_end,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [MAC_W-1:0]          dest_mac,
  output logic [MAC_W-1:0]          source_mac,
  output logic [TYPE_W-1:0]         ether_type,
  output logic [PAYLOAD_W-1:0]      payload_length,
  output logic [FCS_W-1:0]          received_fcs,
  output logic [1:0]                status,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_data
);

  logic        accept;
  logic        buf_full;
  logic        fcs_check_enable;
  frame_view_t view;
  result_t     result;
  result_t     out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fcs_check_enable <= 1'b1;
    end else if (cfg_write) begin
      fcs_check_enable <= cfg_data;
    end
  end

  efp_frame #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_byte(data_byte),
    .frame_end(frame_end),
    .view     (view)
  );

  efp_result u_result (
    .view        (view),
    .check_enable(fcs_check_enable),
    .result      (result)
  );

  efp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .res_valid(accept && frame_end),
    .res      (result),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Result fields.
  assign dest_mac       = out_data.dest;
  assign source_mac     = out_data.source;
  assign ether_type     = out_data.ether_type;
  assign payload_length = out_data.plen;
  assign received_fcs   = out_data.fcs;
  assign status         = out_data.status;

endmodule

`default_nettype wire

/* design/efp_frame.sv */
`timescale 1ns / 1ps
`default_nettype none

module efp_frame
  import efp_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_end,
  output frame_view_t      view
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam int LEN_W = (CNT_W > PAYLOAD_W) ? CNT_W : PAYLOAD_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_BYTES);

  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  byte_count_next;
  logic [31:0]       crc;
  logic [31:0]       crc_next;
  logic [7:0]        footer [4];
  logic [MAC_W-1:0]  dest;
  logic [MAC_W-1:0]  dest_next;
  logic [MAC_W-1:0]  source;
  logic [MAC_W-1:0]  source_next;
  logic [TYPE_W-1:0] ether_type;
  logic [TYPE_W-1:0] ether_type_next;
  logic [LEN_W-1:0]  len_diff;

  // Header capture by byte position.
  always_comb begin
    dest_next       = dest;
    source_next     = source;
    ether_type_next = ether_type;
    if (byte_count < CNT_W'(6)) begin
      dest_next = {dest[MAC_W-9:0], data_byte};
    end else if (byte_count < CNT_W'(12)) begin
      source_next = {source[MAC_W-9:0], data_byte};
    end else if (byte_count < CNT_W'(14)) begin
      ether_type_next = {ether_type[TYPE_W-9:0], data_byte};
    end
  end

  // The CRC takes the byte leaving the footer delay line.
  always_comb begin
    crc_next = crc;
    if (byte_count >= CNT_W'(4) && byte_count <= CNT_MAX) begin
      crc_next = crc32_byte(crc, footer[0]);
    end
  end

  // Byte counter saturates one past the maximum frame size.
  assign byte_count_next = (byte_count <= CNT_MAX) ? byte_count + CNT_W'(1) : byte_count;

  assign len_diff = LEN_W'(byte_count_next) - LEN_W'(CNT_MIN);

  // View of the frame with this byte included.
  always_comb begin
    view.dest       = dest_next;
    view.source     = source_next;
    view.ether_type = ether_type_next;
    view.plen       = len_diff[PAYLOAD_W-1:0];
    view.fcs        = {footer[1], footer[2], footer[3], data_byte};
    view.crc        = ~crc_next;
    view.too_short  = byte_count_next < CNT_MIN;
    view.too_long   = byte_count_next > CNT_MAX;
  end

  // Frame state; the final byte returns everything to its start values.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      crc        <= CRC_INIT;
      footer[0]  <= '0;
      footer[1]  <= '0;
      footer[2]  <= '0;
      footer[3]  <= '0;
      dest       <= '0;
      source     <= '0;
      ether_type <= '0;
    end else if (accept) begin
      if (frame_end) begin
        byte_count <= '0;
        crc        <= CRC_INIT;
        footer[0]  <= '0;
        footer[1]  <= '0;
        footer[2]  <= '0;
        footer[3]  <= '0;
        dest       <= '0;
        source     <= '0;
        ether_type <= '0;
      end else begin
        byte_count <= byte_count_next;
        crc        <= crc_next;
        footer[0]  <= footer[1];
        footer[1]  <= footer[2];
        footer[2]  <= footer[3];
        footer[3]  <= data_byte;
        dest       <= dest_next;
        source     <= source_next;
        ether_type <= ether_type_next;
      end
    end
  end

endmodule

`default_nettype wire

/* design/efp_result.sv */
`timescale 1ns / 1ps
`default_nettype none

module efp_result
  import efp_pkg::*;
(
  input  wire frame_view_t view,
  input  wire logic        check_enable,
  output result_t          result
);

  // Status and length selection for a finished frame.
  always_comb begin
    result.dest       = view.dest;
    result.source     = view.source;
    result.ether_type = view.ether_type;
    result.plen       = '0;
    result.fcs        = view.fcs;
    result.status     = ST_OK;
    if (view.too_long) begin
      result.status = ST_LONG;
    end else if (view.too_short) begin
      result.status = ST_SHORT;
      result.fcs    = '0;
    end else begin
      result.plen = view.plen;
      if (check_enable && (view.fcs != view.crc)) begin
        result.status = ST_MISMATCH;
      end
    end
  end

endmodule

`default_nettype wire

/* design/efp_out_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module efp_out_buf
  import efp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  // Control: the skid entry fills only when the output register is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid && out_stall) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers follow the same decisions.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_stall) begin
        out_data <= skid_data;
      end
    end else if (res_valid) begin
      if (out_valid && out_stall) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

endmodule

`default_nettype wire

/* design/efp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module efp_checker
  import efp_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [MAC_W-1:0]     dest_mac,
  input wire logic [PAYLOAD_W-1:0] payload_length,
  input wire logic [FCS_W-1:0]     received_fcs,
  input wire logic [1:0]           status
);

  // A held result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dest_mac) && $stable(status))
    else $error("held result changed");

  // Input stall only follows a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // A short frame reports no length and no FCS.
  a_short_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_SHORT) |-> (payload_length == '0) && (received_fcs == '0))
    else $error("short frame carries length or FCS");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind ethernet_frame_parser_fcs_check efp_checker u_efp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .dest_mac      (dest_mac),
  .payload_length(payload_length),
  .received_fcs  (received_fcs),
  .status        (status)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import efp_pkg::*;

  localparam int MAX_BYTES = 2048;
  localparam int MIN_LEN = 18;
  localparam logic [31:0] FCS_POLY = 32'hEDB8_8320;
  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_PHASE_BYTES = 300;

  typedef enum int {FK_GOOD, FK_BAD_FCS, FK_NOISE, FK_ZEROS, FK_ONES} frame_kind_t;
  typedef enum int {SM_NONE, SM_LIGHT, SM_HEAVY, SM_SLOW} stall_mode_t;

  // Tracks the deframer state and holds the results that completed frames should produce.
  class frame_scoreboard;
    bit check_on;
    int unsigned count;
    logic [31:0] crc_acc;
    logic [7:0] tail[4];
    logic [47:0] dest_reg;
    logic [47:0] src_reg;
    logic [15:0] type_reg;
    result_t pending[$];
    int errors;
    int frames_seen;
    int status_hits[4];

    function new();
      check_on = 1'b1;
      errors = 0;
      frames_seen = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      count = 0;
      crc_acc = 32'hFFFF_FFFF;
      foreach (tail[i]) tail[i] = 8'h00;
      dest_reg = '0;
      src_reg = '0;
      type_reg = '0;
    endfunction

    // Reflected CRC-32, one data bit at a time.
    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
        if (r[0] ^ b[i]) r = (r >> 1) ^ FCS_POLY;
        else r = r >> 1;
      end
      return r;
    endfunction

    // Called for every accepted byte transfer; queues a result on the last byte.
    function void note_byte(logic [7:0] d, logic last);
      int unsigned pos;
      result_t want;
      pos = count;
      if (pos < 6) dest_reg = {dest_reg[39:0], d};
      else if (pos < 12) src_reg = {src_reg[39:0], d};
      else if (pos < 14) type_reg = {type_reg[7:0], d};

      // The FCS bytes sit in the tail line and never reach the CRC.
      if (pos >= 4 && pos <= MAX_BYTES) crc_acc = crc_step(crc_acc, tail[0]);
      tail[0] = tail[1];
      tail[1] = tail[2];
      tail[2] = tail[3];
      tail[3] = d;
      if (count <= MAX_BYTES) count++;
      if (!last) return;

      want.dest = dest_reg;
      want.source = src_reg;
      want.ether_type = type_reg;
      want.plen = '0;
      want.fcs = {tail[0], tail[1], tail[2], tail[3]};
      if (count > MAX_BYTES) begin
        want.status = ST_LONG;
      end else if (count < MIN_LEN) begin
        want.status = ST_SHORT;
        want.fcs = '0;
      end else begin
        want.plen = 11'(count - MIN_LEN);
        want.status = (check_on && want.fcs != ~crc_acc) ? ST_MISMATCH : ST_OK;
      end
      pending.push_back(want);
      clear_frame();
    endfunction

    function void report_field(string field, logic [63:0] want_v, logic [63:0] got_v);
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v,
               got_v);
    endfunction

    // Compares one result transfer with the oldest queued frame result.
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected nothing, actual dest 0x%0h status %0d",
                 $time, got.dest, got.status);
        return;
      end
      want = pending.pop_front();
      frames_seen++;
      status_hits[want.status]++;
      if (got.dest !== want.dest) report_field("dest_mac", want.dest, got.dest);
      if (got.source !== want.source) report_field("source_mac", want.source, got.source);
      if (got.ether_type !== want.ether_type)
        report_field("ether_type", want.ether_type, got.ether_type);
      if (got.plen !== want.plen) report_field("payload_length", want.plen, got.plen);
      if (got.fcs !== want.fcs) report_field("received_fcs", want.fcs, got.fcs);
      if (got.status !== want.status) report_field("status", want.status, got.status);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] data_byte;
  logic frame_end;
  logic out_valid;
  logic out_stall;
  logic [MAC_W-1:0] dest_mac;
  logic [MAC_W-1:0] source_mac;
  logic [TYPE_W-1:0] ether_type;
  logic [PAYLOAD_W-1:0] payload_length;
  logic [FCS_W-1:0] received_fcs;
  logic [1:0] status;
  logic cfg_write;
  logic cfg_data;

  frame_scoreboard sb;
  int burst_left = 0;
  int cycles = 0;
  int setting_changes = 0;

  ethernet_frame_parser_fcs_check #(
    .MAX_FRAME_BYTES(MAX_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dest_mac(dest_mac),
    .source_mac(source_mac),
    .ether_type(ether_type),
    .payload_length(payload_length),
    .received_fcs(received_fcs),
    .status(status),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               sb.pending.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor: a transfer happens when valid is high and stall is low.
  always @(posedge clk) begin
    result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.dest = dest_mac;
      got.source = source_mac;
      got.ether_type = ether_type;
      got.plen = payload_length;
      got.fcs = received_fcs;
      got.status = status_t'(status);
      sb.check_result(got);
    end
  end

  // Receiver back-pressure, switching between stall patterns every so often.
  initial begin
    stall_mode_t mode;
    int span;
    out_stall = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          SM_NONE: out_stall <= 1'b0;
          SM_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          SM_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 15) == 0) ? ~out_stall : out_stall;
        endcase
      end
    end
  end

  // Drives one byte transfer, inserting idle gaps between bursts of random length.
  task automatic send_item(input logic [7:0] d, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= d;
    frame_end <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(d, last);
  endtask

  // Builds a frame of the given length and kind and sends it byte by byte.
  task automatic send_frame(input int len, input frame_kind_t kind);
    logic [7:0] bytes[$];
    logic [31:0] c;
    int pick;
    for (int i = 0; i < len; i++) begin
      case (kind)
        FK_ZEROS: bytes.push_back(8'h00);
        FK_ONES: bytes.push_back(8'hFF);
        default: bytes.push_back(8'($urandom_range(0, 255)));
      endcase
    end

    // A valid FCS goes in the last four bytes, most significant byte first.
    if ((kind == FK_GOOD || kind == FK_BAD_FCS || kind == FK_ONES) && len >= 4) begin
      c = 32'hFFFF_FFFF;
      for (int i = 0; i < len - 4; i++) c = sb.crc_step(c, bytes[i]);
      c = ~c;
      bytes[len - 4] = c[31:24];
      bytes[len - 3] = c[23:16];
      bytes[len - 2] = c[15:8];
      bytes[len - 1] = c[7:0];
    end

    // A single flipped bit anywhere in the frame always breaks the CRC.
    if (kind == FK_BAD_FCS) begin
      pick = $urandom_range(0, len - 1);
      bytes[pick][$urandom_range(0, 7)] ^= 1'b1;
    end

    for (int i = 0; i < len; i++) send_item(bytes[i], i == len - 1);
  endtask

  // Mostly well-formed frames with random content, plus short and corrupted ones.
  task automatic random_frames(input int budget);
    int sent;
    int r;
    int len;
    frame_kind_t kind;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = $urandom_range(1, MIN_LEN - 1);
      else if (r < 20) len = $urandom_range(MIN_LEN, MIN_LEN + 4);
      else if (r < 85) len = $urandom_range(MIN_LEN + 5, 80);
      else len = $urandom_range(81, 300);
      r = $urandom_range(0, 99);
      kind = (r < 75) ? FK_GOOD : (r < 90) ? FK_BAD_FCS : FK_NOISE;
      send_frame(len, kind);
      sent += len;
    end
  endtask

  // Register write, only once the block has drained every pending result.
  task automatic set_fcs_check(input logic en);
    @(negedge clk);
    in_valid <= 1'b0;
    frame_end <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= en;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.check_on = en;
    setting_changes++;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    frame_end = 1'b0;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames with the check enabled: the short-frame limit and CRC outcomes.
    set_fcs_check(1'b1);
    send_frame(1, FK_ONES);
    send_frame(MIN_LEN - 1, FK_NOISE);
    send_frame(MIN_LEN, FK_ONES);
    send_frame(MIN_LEN, FK_ZEROS);
    send_frame(64, FK_GOOD);
    send_frame(64, FK_BAD_FCS);

    // With the check disabled a corrupted frame of legal length passes.
    set_fcs_check(1'b0);
    send_frame(MIN_LEN, FK_ZEROS);
    send_frame(64, FK_BAD_FCS);
    send_frame(10, FK_NOISE);

    // Random traffic, alternating the check setting between phases.
    random_frames(RANDOM_PHASE_BYTES);
    set_fcs_check(1'b1);
    random_frames(RANDOM_PHASE_BYTES);
    set_fcs_check(1'b0);
    random_frames(RANDOM_PHASE_BYTES);
    set_fcs_check(1'b1);
    random_frames(RANDOM_PHASE_BYTES);

    // Drain the remaining results and let the block settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d frames: %0d ok, %0d too short, %0d FCS mismatch, %0d too long.",
             sb.frames_seen, sb.status_hits[ST_OK], sb.status_hits[ST_SHORT],
             sb.status_hits[ST_MISMATCH], sb.status_hits[ST_LONG]);
    $display("FCS check setting written %0d times; %0d field errors over %0d cycles.",
             setting_changes, sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* ethernet_frame_parser_fcs_check.f */
design/efp_pkg.sv
design/efp_frame.sv
design/efp_result.sv
design/efp_out_buf.sv
design/ethernet_frame_parser_fcs_check.sv
design/efp_checker.sv
tb/testbench.sv
